// File: rtl/psg_pkg.sv
// Shared types, codes and the level table of the three-voice sound generator.
package psg_pkg;

  localparam int NVOICE = 3;

  // command opcodes
  localparam logic [1:0] OP_TICK   = 2'd0;
  localparam logic [1:0] OP_SELECT = 2'd1;
  localparam logic [1:0] OP_WRITE  = 2'd2;

  // register indexes
  localparam logic [3:0] REG_TONE_A_FINE   = 4'd0;
  localparam logic [3:0] REG_TONE_A_COARSE = 4'd1;
  localparam logic [3:0] REG_TONE_B_FINE   = 4'd2;
  localparam logic [3:0] REG_TONE_B_COARSE = 4'd3;
  localparam logic [3:0] REG_TONE_C_FINE   = 4'd4;
  localparam logic [3:0] REG_TONE_C_COARSE = 4'd5;
  localparam logic [3:0] REG_NOISE_PER     = 4'd6;
  localparam logic [3:0] REG_MIXER         = 4'd7;
  localparam logic [3:0] REG_VOL_A         = 4'd8;
  localparam logic [3:0] REG_VOL_B         = 4'd9;
  localparam logic [3:0] REG_VOL_C         = 4'd10;
  localparam logic [3:0] REG_ENV_FINE      = 4'd11;
  localparam logic [3:0] REG_ENV_COARSE    = 4'd12;
  localparam logic [3:0] REG_ENV_SHAPE     = 4'd13;

  localparam logic [16:0] NOISE_SHIFT_RESET = 17'h0FFFF;
  localparam logic [17:0] NOISE_TAPS        = 18'h24000;
  localparam logic [9:0]  NOISE_PER_RESET   = 10'd992;
  localparam logic [9:0]  NOISE_PER_MIN     = 10'd16;
  localparam logic [19:0] ENV_CNT_MAX       = 20'hFFFFF;
  localparam logic [4:0]  ENV_TOP           = 5'h1F;

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] reg_value;
  } cmd_t;

  typedef struct packed {
    logic [7:0] voice_a_level;
    logic [7:0] voice_b_level;
    logic [7:0] voice_c_level;
  } snd_t;

  typedef struct packed {
    logic       tick;
    logic       wr_fine;
    logic       wr_coarse;
    logic       wr_shape;
    logic [7:0] data;
  } env_ctrl_t;

  // exponential level table, two entries per step
  function automatic logic [7:0] level_lut(input logic [4:0] idx);
    logic [7:0] lv;
    case (idx[4:1])
      4'd0:    lv = 8'd1;
      4'd1:    lv = 8'd2;
      4'd2:    lv = 8'd3;
      4'd3:    lv = 8'd4;
      4'd4:    lv = 8'd6;
      4'd5:    lv = 8'd8;
      4'd6:    lv = 8'd11;
      4'd7:    lv = 8'd16;
      4'd8:    lv = 8'd23;
      4'd9:    lv = 8'd32;
      4'd10:   lv = 8'd45;
      4'd11:   lv = 8'd64;
      4'd12:   lv = 8'd90;
      4'd13:   lv = 8'd128;
      4'd14:   lv = 8'd181;
      default: lv = 8'd255;
    endcase
    return lv;
  endfunction

endpackage

// File: rtl/psg_env.sv
// Envelope generator: period counter, level ramp and shape sequencing.
module psg_env (
  input  logic                clk,
  input  logic                rst,
  input  psg_pkg::env_ctrl_t  ctrl,
  output logic [4:0]          level_next
);

  logic [15:0] period;
  logic [19:0] count;
  logic [5:0]  level;
  logic [3:0]  shape;
  logic        hold;

  logic [19:0] count_inc;
  logic        fire;
  logic [19:0] count_tick;
  logic [5:0]  level_ramp;
  logic [5:0]  level_tick;
  logic [3:0]  shape_alt;
  logic [3:0]  shape_tick;
  logic        hold_tick;

  always_comb begin
    count_inc  = (count != psg_pkg::ENV_CNT_MAX) ? count + 20'd1 : count;
    fire       = (period != 16'd0) && (count_inc >= {period, 4'h0});
    count_tick = fire ? 20'd0 : count_inc;
    level_ramp = level;
    if (fire && !hold) begin
      level_ramp = shape[2] ? level + 6'd1 : level - 6'd1;
    end
    // alternate on shapes whose low bits are 01 or 10
    shape_alt = shape;
    if (shape[1:0] == 2'b01 || shape[1:0] == 2'b10) begin
      shape_alt = shape ^ 4'b0100;
    end
    shape_tick = shape;
    hold_tick  = hold;
    level_tick = level_ramp;
    if (fire && level_ramp[5]) begin
      if (shape[3]) begin
        shape_tick = shape_alt;
        hold_tick  = hold | shape_alt[0];
        level_tick = shape_alt[2] ? 6'd0 : {1'b0, psg_pkg::ENV_TOP};
      end else begin
        hold_tick  = 1'b1;
        level_tick = 6'd0;
      end
    end
    level_next = ctrl.tick ? level_tick[4:0] : level[4:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      period <= '0;
      count  <= '0;
      level  <= '0;
      shape  <= '0;
      hold   <= 1'b1;
    end else begin
      if (ctrl.tick) begin
        count <= count_tick;
        level <= level_tick;
        shape <= shape_tick;
        hold  <= hold_tick;
      end
      if (ctrl.wr_fine) begin
        period[7:0] <= ctrl.data;
      end
      if (ctrl.wr_coarse) begin
        period[15:8] <= ctrl.data;
      end
      if (ctrl.wr_shape) begin
        count <= '0;
        shape <= ctrl.data[3:0];
        hold  <= 1'b0;
        level <= ctrl.data[2] ? 6'd0 : {1'b0, psg_pkg::ENV_TOP};
      end
    end
  end

endmodule

// File: rtl/psg_three_voice_tone_noise_envelope_unit.sv
// Top level of the three-voice tone, noise and envelope sound generator.
// Each command item is a register select, a data write to the selected
// register, or one tick. The whole update of tone, noise and envelope
// counters and the level lookup sit between the command port and a result
// register, so an item can be taken every cycle while cmd_stall is low.
// A tick gives one result item with the three voice levels (0 to 255) after
// that tick; select and write items give none. A two-deep output buffer
// (result register plus skid register) keeps commands flowing while a result
// waits; cmd_stall rises only when both are full. Registers 14 and 15 and
// opcode 3 are ignored.
module psg_three_voice_tone_noise_envelope_unit (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_valid,
  output logic          cmd_stall,
  input  psg_pkg::cmd_t cmd,
  output logic          snd_valid,
  input  logic          snd_stall,
  output psg_pkg::snd_t snd
);

  localparam int NV = psg_pkg::NVOICE;

  // register file and counters
  logic [3:0]  sel;
  logic [11:0] tone_per [NV];
  logic [15:0] tone_cnt [NV];
  logic [NV-1:0] sq_high;
  logic [NV-1:0] tone_off;
  logic [NV-1:0] noise_off;
  logic [NV-1:0] vol_env;
  logic [3:0]  vol_lvl [NV];
  logic [9:0]  noise_per;
  logic [9:0]  noise_cnt;
  logic [16:0] noise_shift;

  // output buffer
  psg_pkg::snd_t skid;
  logic          skid_valid;

  logic cmd_acc;
  logic tick;
  logic wr;
  logic sel_wr;

  logic [15:0]   tone_cnt_next [NV];
  logic [NV-1:0] sq_high_next;
  logic [9:0]    noise_cnt_inc;
  logic          noise_fire;
  logic [17:0]   noise_fb;
  logic [16:0]   noise_shift_next;
  logic [4:0]    env_level_next;
  logic [7:0]    lvl [NV];
  psg_pkg::snd_t res;
  psg_pkg::env_ctrl_t env_ctrl;
  logic          out_free;

  assign cmd_stall = skid_valid;
  assign cmd_acc   = cmd_valid && !cmd_stall;
  assign tick      = cmd_acc && (cmd.opcode == psg_pkg::OP_TICK);
  assign wr        = cmd_acc && (cmd.opcode == psg_pkg::OP_WRITE);
  assign sel_wr    = cmd_acc && (cmd.opcode == psg_pkg::OP_SELECT);

  // envelope writes travel to the envelope block together with the tick
  always_comb begin
    env_ctrl.tick      = tick;
    env_ctrl.wr_fine   = wr && (sel == psg_pkg::REG_ENV_FINE);
    env_ctrl.wr_coarse = wr && (sel == psg_pkg::REG_ENV_COARSE);
    env_ctrl.wr_shape  = wr && (sel == psg_pkg::REG_ENV_SHAPE);
    env_ctrl.data      = cmd.reg_value;
  end

  psg_env u_env (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (env_ctrl),
    .level_next (env_level_next)
  );

  // noise: 17-bit shift register, tap word spills into bit 17 before the shift
  always_comb begin
    noise_cnt_inc    = noise_cnt + 10'd1;
    noise_fire       = noise_cnt_inc >= noise_per;
    noise_fb         = {1'b0, noise_shift} ^ (noise_shift[0] ? psg_pkg::NOISE_TAPS : 18'd0);
    noise_shift_next = noise_fire ? noise_fb[17:1] : noise_shift;
  end

  // per voice: tone counter, square wave, level gating
  for (genvar i = 0; i < NV; i++) begin : g_voice
    logic [15:0] cnt_inc;
    logic        wrap;
    logic [4:0]  idx;
    logic        mute;
    always_comb begin
      cnt_inc          = tone_cnt[i] + 16'd1;
      wrap             = cnt_inc >= {tone_per[i], 4'h0};
      tone_cnt_next[i] = wrap ? 16'd0 : cnt_inc;
      sq_high_next[i]  = sq_high[i] ^ wrap;
      idx  = vol_env[i] ? env_level_next : {vol_lvl[i], 1'b0};
      // a period of zero keeps the tone gate open
      mute = (!tone_off[i] && !sq_high_next[i] && (tone_per[i] != 12'd0)) ||
             (!noise_off[i] && !noise_shift_next[0]);
      lvl[i] = mute ? 8'd0 : psg_pkg::level_lut(idx);
    end
  end

  always_comb begin
    res.voice_a_level = lvl[0];
    res.voice_b_level = lvl[1];
    res.voice_c_level = lvl[2];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sel         <= '0;
      sq_high     <= '0;
      tone_off    <= '1;
      noise_off   <= '1;
      vol_env     <= '0;
      noise_per   <= psg_pkg::NOISE_PER_RESET;
      noise_cnt   <= '0;
      noise_shift <= psg_pkg::NOISE_SHIFT_RESET;
      for (int i = 0; i < NV; i++) begin
        tone_per[i] <= '0;
        tone_cnt[i] <= '0;
        vol_lvl[i]  <= '0;
      end
    end else begin
      if (sel_wr) begin
        sel <= cmd.reg_value[3:0];
      end
      if (wr) begin
        case (sel)
          psg_pkg::REG_TONE_A_FINE:   tone_per[0][7:0]  <= cmd.reg_value;
          psg_pkg::REG_TONE_A_COARSE: tone_per[0][11:8] <= cmd.reg_value[3:0];
          psg_pkg::REG_TONE_B_FINE:   tone_per[1][7:0]  <= cmd.reg_value;
          psg_pkg::REG_TONE_B_COARSE: tone_per[1][11:8] <= cmd.reg_value[3:0];
          psg_pkg::REG_TONE_C_FINE:   tone_per[2][7:0]  <= cmd.reg_value;
          psg_pkg::REG_TONE_C_COARSE: tone_per[2][11:8] <= cmd.reg_value[3:0];
          psg_pkg::REG_NOISE_PER: begin
            noise_per <= (cmd.reg_value == 8'd0) ? psg_pkg::NOISE_PER_MIN
                                                 : {cmd.reg_value[4:0], 5'd0};
          end
          psg_pkg::REG_MIXER: begin
            tone_off  <= cmd.reg_value[2:0];
            noise_off <= cmd.reg_value[5:3];
          end
          psg_pkg::REG_VOL_A: begin
            vol_env[0] <= cmd.reg_value[4];
            vol_lvl[0] <= cmd.reg_value[3:0];
          end
          psg_pkg::REG_VOL_B: begin
            vol_env[1] <= cmd.reg_value[4];
            vol_lvl[1] <= cmd.reg_value[3:0];
          end
          psg_pkg::REG_VOL_C: begin
            vol_env[2] <= cmd.reg_value[4];
            vol_lvl[2] <= cmd.reg_value[3:0];
          end
          default: ;
        endcase
      end
      if (tick) begin
        noise_cnt   <= noise_fire ? 10'd0 : noise_cnt_inc;
        noise_shift <= noise_shift_next;
        sq_high     <= sq_high_next;
        for (int i = 0; i < NV; i++) begin
          tone_cnt[i] <= tone_cnt_next[i];
        end
      end
    end
  end

  // result register with skid stage
  assign out_free = !snd_valid || !snd_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      snd_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_free) begin
      if (skid_valid) begin
        snd_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        snd_valid <= tick;
      end
    end else if (tick) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      snd <= skid_valid ? skid : res;
    end else if (tick) begin
      skid <= res;
    end
  end

endmodule

// File: rtl/psg_chk.sv
// Port-level checker for the sound generator top level, with its bind.
module psg_chk (
  input logic          clk,
  input logic          rst,
  input logic          cmd_valid,
  input logic          cmd_stall,
  input psg_pkg::cmd_t cmd,
  input logic          snd_valid,
  input logic          snd_stall,
  input psg_pkg::snd_t snd
);

  // commands are held back only while a result is waiting
  a_stall_needs_result: assert property (@(posedge clk) disable iff (rst)
    cmd_stall |-> snd_valid)
    else $error("cmd_stall without a waiting result");

  // stall only rises after a tick was taken into a blocked output
  a_stall_rise: assert property (@(posedge clk) disable iff (rst)
    $rose(cmd_stall) |-> $past(snd_valid && snd_stall && cmd_valid && !cmd_stall &&
                               cmd.opcode == psg_pkg::OP_TICK))
    else $error("cmd_stall rose without cause");

  // a tick into a free output shows a result next cycle
  a_tick_result: assert property (@(posedge clk) disable iff (rst)
    (cmd_valid && !cmd_stall && cmd.opcode == psg_pkg::OP_TICK &&
     (!snd_valid || !snd_stall)) |=> snd_valid)
    else $error("tick gave no result");

  // non-tick items never make results
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    (cmd_valid && !cmd_stall && cmd.opcode != psg_pkg::OP_TICK && !snd_valid) |=> !snd_valid)
    else $error("result without a tick");

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (snd_valid && snd_stall) |=> (snd_valid && $stable(snd)))
    else $error("stalled result changed");

endmodule

bind psg_three_voice_tone_noise_envelope_unit psg_chk u_psg_chk (.*);

// File: tb/psg_three_voice_tone_noise_envelope_unit_test.sv
`timescale 1ns / 1ps
// Self-checking testbench of the three-voice tone, noise and envelope sound generator.
module psg_three_voice_tone_noise_envelope_unit_test;

  // opcode and register indexes the package leaves unnamed
  localparam logic [1:0] OP_UNUSED    = 2'd3;
  localparam logic [3:0] REG_SPARE_LO = 4'd14;
  localparam logic [3:0] REG_SPARE_HI = 4'd15;

  localparam int NVOICE       = psg_pkg::NVOICE;
  localparam int CYCLE_LIMIT  = 600000;
  localparam int RANDOM_ITEMS = 40;
  localparam int SWEEP_TICKS  = 516;
  localparam int SETTLE_WAIT  = 24;

  logic clk;
  logic rst       = 1'b1;
  logic cmd_valid = 1'b0;
  logic cmd_stall;
  psg_pkg::cmd_t cmd = '0;
  logic snd_valid;
  logic snd_stall = 1'b0;
  psg_pkg::snd_t snd;

  int errors    = 0;
  int cycles    = 0;
  int recv_hold = 0;
  // eager sides never idle; set per stretch of stimulus
  bit send_eager = 1'b0;
  bit recv_eager = 1'b0;

  // level triples still owed by the block, oldest first
  psg_pkg::snd_t levels_due[$];

  // exponential amplitude steps, two entries per step
  logic [7:0] amp_table [32] = '{
    8'd1,   8'd1,   8'd2,   8'd2,   8'd3,   8'd3,   8'd4,   8'd4,
    8'd6,   8'd6,   8'd8,   8'd8,   8'd11,  8'd11,  8'd16,  8'd16,
    8'd23,  8'd23,  8'd32,  8'd32,  8'd45,  8'd45,  8'd64,  8'd64,
    8'd90,  8'd90,  8'd128, 8'd128, 8'd181, 8'd181, 8'd255, 8'd255
  };

  // predicted generator state
  logic [3:0]  latched_reg;
  int unsigned tone_per [NVOICE];
  int unsigned tone_cnt [NVOICE];
  bit          square [NVOICE];
  bit          tone_mask [NVOICE];
  bit          noise_mask [NVOICE];
  logic [5:0]  vol [NVOICE];
  int unsigned noise_per;
  int unsigned noise_cnt;
  logic [17:0] lfsr;
  int unsigned env_per;
  int unsigned env_cnt;
  logic [5:0]  env_lvl;
  logic [3:0]  env_shp;
  bit          env_frozen;

  psg_three_voice_tone_noise_envelope_unit dut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .snd_valid (snd_valid),
    .snd_stall (snd_stall),
    .snd       (snd)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // hard stop if the run hangs
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic int draw_wait(input bit eager);
    return eager ? 0 : int'($urandom_range(0, 19));
  endfunction

  // ---------------------------------------------------------------- predictor

  task automatic reset_generator();
    latched_reg = '0;
    for (int i = 0; i < NVOICE; i++) begin
      tone_per[i]   = 0;
      tone_cnt[i]   = 0;
      square[i]     = 1'b0;
      tone_mask[i]  = 1'b1;
      noise_mask[i] = 1'b1;
      vol[i]        = '0;
    end
    noise_per  = 32'(psg_pkg::NOISE_PER_RESET);
    noise_cnt  = 0;
    lfsr       = {1'b0, psg_pkg::NOISE_SHIFT_RESET};
    env_per    = 0;
    env_cnt    = 0;
    env_lvl    = '0;
    env_shp    = '0;
    env_frozen = 1'b1;
  endtask

  task automatic load_register(input logic [7:0] val);
    int unsigned d;
    int          v;
    d = 32'(val);
    v = int'(latched_reg[3:1]);
    case (latched_reg)
      psg_pkg::REG_TONE_A_FINE, psg_pkg::REG_TONE_B_FINE,
      psg_pkg::REG_TONE_C_FINE: begin
        tone_per[v] = (tone_per[v] & 32'hF000) | (d << 4);
      end
      psg_pkg::REG_TONE_A_COARSE, psg_pkg::REG_TONE_B_COARSE,
      psg_pkg::REG_TONE_C_COARSE: begin
        tone_per[v] = (tone_per[v] & 32'h0FF0) | ((d & 32'hF) << 12);
      end
      psg_pkg::REG_NOISE_PER: begin
        noise_per = (d != 0) ? ((d & 32'h1F) << 5) : 32'(psg_pkg::NOISE_PER_MIN);
      end
      psg_pkg::REG_MIXER: begin
        for (int i = 0; i < NVOICE; i++) begin
          tone_mask[i]  = val[i];
          noise_mask[i] = val[i + 3];
        end
      end
      psg_pkg::REG_VOL_A, psg_pkg::REG_VOL_B, psg_pkg::REG_VOL_C: begin
        vol[latched_reg - psg_pkg::REG_VOL_A] = {val[4:0], 1'b0};
      end
      psg_pkg::REG_ENV_FINE: begin
        env_per = (env_per & 32'hFF000) | (d << 4);
      end
      psg_pkg::REG_ENV_COARSE: begin
        env_per = (env_per & 32'h00FF0) | (d << 12);
      end
      psg_pkg::REG_ENV_SHAPE: begin
        // shape write restarts the envelope
        env_cnt    = 0;
        env_shp    = val[3:0];
        env_frozen = 1'b0;
        env_lvl    = val[2] ? 6'd0 : 6'h1F;
      end
      default: begin
      end
    endcase
  endtask

  task automatic step_envelope();
    if (env_cnt < 32'hFFFFF) env_cnt++;
    if (env_per != 0 && env_cnt >= env_per) begin
      env_cnt = 0;
      if (!env_frozen) env_lvl = env_shp[2] ? env_lvl + 6'd1 : env_lvl - 6'd1;
      if (env_lvl[5]) begin
        // ran off either end of the ramp
        if (env_shp[3]) begin
          if (env_shp[1:0] == 2'd1 || env_shp[1:0] == 2'd2) env_shp[2] = ~env_shp[2];
          if (env_shp[0]) env_frozen = 1'b1;
          env_lvl = env_shp[2] ? 6'd0 : 6'h1F;
        end else begin
          env_frozen = 1'b1;
          env_lvl    = '0;
        end
      end
    end
  endtask

  function automatic logic [7:0] voice_out(input int i);
    logic [4:0] idx;
    logic [7:0] lv;
    idx = vol[i][5] ? env_lvl[4:0] : vol[i][4:0];
    lv  = amp_table[idx];
    // tone periods below two leave the voice sounding
    if (!tone_mask[i] && !square[i] && tone_per[i] >= 2) lv = '0;
    if (!noise_mask[i] && !lfsr[0]) lv = '0;
    return lv;
  endfunction

  task automatic advance_tick();
    psg_pkg::snd_t lv;
    step_envelope();
    noise_cnt++;
    if (noise_cnt >= noise_per) begin
      noise_cnt = 0;
      if (lfsr[0]) lfsr = lfsr ^ psg_pkg::NOISE_TAPS;
      lfsr = lfsr >> 1;
    end
    for (int i = 0; i < NVOICE; i++) begin
      tone_cnt[i]++;
      if (tone_cnt[i] >= tone_per[i]) begin
        tone_cnt[i] = 0;
        square[i]   = ~square[i];
      end
    end
    lv.voice_a_level = voice_out(0);
    lv.voice_b_level = voice_out(1);
    lv.voice_c_level = voice_out(2);
    levels_due.push_back(lv);
  endtask

  task automatic predict_item(input psg_pkg::cmd_t c);
    case (c.opcode)
      psg_pkg::OP_TICK:   advance_tick();
      psg_pkg::OP_SELECT: latched_reg = c.reg_value[3:0];
      psg_pkg::OP_WRITE:  load_register(c.reg_value);
      default: begin
      end
    endcase
  endtask

  // ----------------------------------------------------------------- checking

  task automatic compare_level(input string field, input logic [7:0] want,
                               input logic [7:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      errors++;
    end
  endtask

  task automatic check_levels(input psg_pkg::snd_t got);
    psg_pkg::snd_t want;
    if (levels_due.size() == 0) begin
      $error("result item with no tick outstanding: %p", got);
      errors++;
    end else begin
      want = levels_due.pop_front();
      compare_level("voice_a_level", want.voice_a_level, got.voice_a_level);
      compare_level("voice_b_level", want.voice_b_level, got.voice_b_level);
      compare_level("voice_c_level", want.voice_c_level, got.voice_c_level);
    end
  endtask

  // receiver: checks each accepted result, then stalls for a drawn spell
  always @(posedge clk) begin
    if (!rst) begin
      if (snd_valid && !snd_stall) begin
        check_levels(snd);
        recv_hold = draw_wait(recv_eager);
      end else if (recv_hold > 0) begin
        recv_hold--;
      end
      snd_stall <= (recv_hold > 0);
    end
  end

  // ------------------------------------------------------------------- sender

  // valid stays high across back-to-back items; dropped only for a gap
  task automatic send_item(input logic [1:0] op, input logic [7:0] val);
    int gap;
    gap = draw_wait(send_eager);
    if (gap > 0) begin
      cmd_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_valid <= 1'b1;
    cmd       <= psg_pkg::cmd_t'{opcode: op, reg_value: val};
    @(posedge clk);
    while (cmd_stall) @(posedge clk);
    predict_item(psg_pkg::cmd_t'{opcode: op, reg_value: val});
  endtask

  // select (with junk in the upper nibble) then write
  task automatic write_reg(input logic [3:0] r, input logic [7:0] val);
    logic [3:0] junk;
    junk = 4'($urandom_range(0, 15));
    send_item(psg_pkg::OP_SELECT, {junk, r});
    send_item(psg_pkg::OP_WRITE, val);
  endtask

  // hold off until the block owes nothing
  task automatic wait_for_levels();
    cmd_valid <= 1'b0;
    do @(posedge clk); while (levels_due.size() != 0);
  endtask

  // mostly small periods so that tones and envelope move within the run
  function automatic logic [7:0] pick_value(input logic [3:0] r);
    logic [7:0] v;
    v = 8'($urandom);
    if ($urandom_range(0, 2) != 0) begin
      case (r)
        psg_pkg::REG_TONE_A_FINE, psg_pkg::REG_TONE_B_FINE,
        psg_pkg::REG_TONE_C_FINE, psg_pkg::REG_ENV_FINE: begin
          v = 8'($urandom_range(0, 3));
        end
        psg_pkg::REG_TONE_A_COARSE, psg_pkg::REG_TONE_B_COARSE,
        psg_pkg::REG_TONE_C_COARSE: begin
          v[3:0] = 4'h0;
        end
        psg_pkg::REG_ENV_COARSE: begin
          v = 8'h00;
        end
        default: begin
        end
      endcase
    end
    return v;
  endfunction

  // -------------------------------------------------------------------- tests

  task automatic test_directed();
    send_eager = 1'b0;
    recv_eager = 1'b0;
    send_item(psg_pkg::OP_TICK, 8'h00);           // straight out of reset
    send_item(OP_UNUSED, 8'hFF);                  // dead opcode, no result
    send_item(psg_pkg::OP_SELECT, 8'hFF);         // spare register, upper nibble ignored
    send_item(psg_pkg::OP_WRITE, 8'h00);
    write_reg(psg_pkg::REG_MIXER, 8'h00);         // every tone and noise on; A period zero
    write_reg(psg_pkg::REG_TONE_B_FINE, 8'h01);   // shortest real tone period
    write_reg(psg_pkg::REG_TONE_C_FINE, 8'hFF);
    write_reg(psg_pkg::REG_TONE_C_COARSE, 8'hFF); // longest period, top nibble dropped
    write_reg(psg_pkg::REG_VOL_A, 8'hFF);         // A follows the envelope
    write_reg(psg_pkg::REG_VOL_B, 8'h0F);         // loudest fixed volume
    write_reg(psg_pkg::REG_NOISE_PER, 8'h20);     // low five bits clear: noise every tick
    write_reg(psg_pkg::REG_ENV_SHAPE, 8'hFF);     // only the shape nibble is kept
    send_item(psg_pkg::OP_TICK, 8'hFF);
    send_item(psg_pkg::OP_TICK, 8'h5A);           // envelope period still zero
    write_reg(psg_pkg::REG_ENV_FINE, 8'h01);
    send_item(psg_pkg::OP_TICK, 8'hA5);
  endtask

  // bursts of register writes followed by runs of ticks, with stray items
  task automatic test_random_traffic();
    int         issued;
    int         run;
    logic [1:0] op;
    logic [3:0] r;
    logic [7:0] v;
    issued = 0;
    while (issued < RANDOM_ITEMS) begin
      send_eager = ($urandom_range(0, 3) == 0);
      recv_eager = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 4) == 0) begin
        // noise: any opcode, any byte, writes without a fresh select
        op = 2'($urandom_range(0, 3));
        v  = 8'($urandom);
        send_item(op, v);
        issued++;
      end else begin
        repeat ($urandom_range(1, 3)) begin
          r = 4'($urandom_range(0, 15));
          // restarting the envelope too often keeps it near the top
          if (r == psg_pkg::REG_ENV_SHAPE && $urandom_range(0, 5) != 0) begin
            r = psg_pkg::REG_MIXER;
          end
          write_reg(r, pick_value(r));
          issued += 2;
        end
        run = int'($urandom_range(1, 30));
        repeat (run) begin
          v = 8'($urandom);
          send_item(psg_pkg::OP_TICK, v);
        end
        issued += run;
      end
    end
  endtask

  // long envelope at the shortest period: runs past the end of the ramp
  task automatic test_envelope_sweep(input logic [3:0] shape, input int ticks);
    logic [7:0] v;
    send_eager = 1'b0;
    recv_eager = 1'b0;
    write_reg(psg_pkg::REG_ENV_FINE, 8'h01);
    write_reg(psg_pkg::REG_ENV_COARSE, 8'h00);
    v = 8'($urandom);
    v[4] = 1'b1;
    write_reg(psg_pkg::REG_VOL_A, v);
    v = 8'($urandom);
    v[4] = 1'b1;
    write_reg(psg_pkg::REG_VOL_B, v);
    v = 8'($urandom);
    write_reg(psg_pkg::REG_VOL_C, v);
    v = 8'($urandom);
    write_reg(psg_pkg::REG_MIXER, v);
    v = 8'($urandom);
    v[3:0] = shape;
    write_reg(psg_pkg::REG_ENV_SHAPE, v);
    for (int n = 0; n < ticks; n++) begin
      if (n % 64 == 0) begin
        send_eager = ($urandom_range(0, 3) == 0);
        recv_eager = ($urandom_range(0, 3) == 0);
      end
      v = 8'($urandom);
      send_item(psg_pkg::OP_TICK, v);
    end
  endtask

  initial begin
    reset_generator();
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    test_directed();
    wait_for_levels();
    test_random_traffic();
    wait_for_levels();
    test_envelope_sweep(4'($urandom_range(0, 15)), SWEEP_TICKS);
    wait_for_levels();

    // let any stray result show itself
    recv_eager = 1'b1;
    repeat (SETTLE_WAIT) @(posedge clk);
    if (errors == 0 && levels_due.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
